FILE: rtl/assert_macros.svh
// assertion macros shared by the rtl files
// expects signals named clock and reset in the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define CHECK_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked out of reset
`define CHECK_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/sitda_pkg.sv
// package for the signed integer to decimal ascii converter
// types, constants and codes shared by all rtl modules; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sitda_pkg;

   localparam int VALUE_W        = 64;  // width of the request value field
   localparam int SIZE_W         = 8;   // width of buffer_size
   localparam int LEN_W          = 5;   // width of the length field
   localparam int VALUE_BITS_DEF = 64;  // default integer width used
   localparam int DIGIT_COUNT    = 19;  // bcd digits for magnitudes up to 2**63
   localparam int DIGIT_IDX_W    = $clog2(DIGIT_COUNT);
   localparam int QUEUE_DEPTH    = 2;
   localparam int QUEUE_PTR_W    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W    = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] ASCII_ZERO  = 8'h30;
   localparam logic [7:0] ASCII_MINUS = 8'h2d;
   localparam logic [3:0] DABBLE_MIN  = 4'd5;
   localparam logic [3:0] DABBLE_ADD  = 4'd3;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic [SIZE_W-1:0]         buffer_size;
   } req_type;

   typedef struct packed {
      logic [7:0]       ch;
      logic             char_valid;
      logic             last;
      logic [LEN_W-1:0] length;
   } rsp_type;

   // classified request as it waits in the queue
   typedef struct packed {
      logic [VALUE_W-1:0] mag;
      logic               neg;
      logic [SIZE_W-1:0]  cap;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_CONVERT,
      BK_COUNT,
      BK_EMIT
   } back_state_type;

endpackage

`default_nettype wire

FILE: rtl/signed_int_to_decimal_ascii_top.sv
// top level of the signed integer to decimal ascii converter
// depends on sitda_pkg, sitda_front, sitda_fifo, sitda_back
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  handshake            payload
// req_      in   req_valid/req_ready  req_type: value, buffer_size
// rsp_      out  rsp_valid/rsp_ready  rsp_type: ch, char_valid, last, length
//
// in the back end a request runs through the bit-serial double dabble loop and a digit
//   count, then emits one character per cycle (or one empty item) while rsp_ready allows
// the front end and two entry queue take new requests while the back end works
// reset clears the queue, the back end state machine and the response valid
// a stalled rsp_ready holds the response register and stops character output

module signed_int_to_decimal_ascii_top
   import sitda_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   // classified request from front end into the queue
   logic           push;
   job_type        push_job;
   // queue head toward the back end
   logic           pop;
   job_type        head_job;
   queue_stat_type q_stat;

   // sign split and capacity clamp, combinational, no state of its own
   sitda_front #(
      .VALUE_BITS(VALUE_BITS)
   ) u_front (
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_stat    (q_stat),
      .push      (push),
      .job       (push_job)
   );

   // decouples request acceptance from conversion
   sitda_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_job),
      .pop       (pop),
      .pop_data  (head_job),
      .stat      (q_stat)
   );

   // conversion and character emission with registered response
   sitda_back #(
      .VALUE_BITS(VALUE_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_stat    (q_stat),
      .job       (head_job),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

FILE: rtl/sitda_front.sv
// front end: accepts requests, splits sign from magnitude, clamps capacity
// depends on sitda_pkg
`timescale 1ns / 1ps
`default_nettype none

module sitda_front
   import sitda_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEF
) (
   input  wire logic           req_valid,
   output logic                req_ready,
   input  wire req_type        req_data,
   input  wire queue_stat_type q_stat,
   output logic                push,
   output job_type             job
);

   logic [VALUE_BITS-1:0] v;
   logic [VALUE_BITS-1:0] mag_v;
   logic                  neg;

   assign req_ready = !q_stat.full;
   assign push      = req_valid && !q_stat.full;

   always_comb begin
      v     = req_data.value[VALUE_BITS-1:0];
      neg   = v[VALUE_BITS-1];
      // most negative value wraps to itself, read as unsigned it is exact
      mag_v = neg ? (~v + VALUE_BITS'(1)) : v;
      job.mag = VALUE_W'(mag_v);
      job.neg = neg;
      // capacity without the terminator, size zero counts as one
      job.cap = (req_data.buffer_size == '0) ? '0 : (req_data.buffer_size - SIZE_W'(1));
   end

endmodule

`default_nettype wire

FILE: rtl/sitda_fifo.sv
// two entry queue of classified requests between front and back
// depends on sitda_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none

module sitda_fifo
   import sitda_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire job_type  push_data,
   input  wire logic     pop,
   output job_type       pop_data,
   output queue_stat_type stat
);

   job_type                mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   do_push, do_pop;

   assign stat.full  = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign stat.empty = (count_ff == '0);
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && !stat.empty;
   assign pop_data   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? (wr_ptr_ff + QUEUE_PTR_W'(1)) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? (rd_ptr_ff + QUEUE_PTR_W'(1)) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QUEUE_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

`include "assert_macros.svh"

   `CHECK_NOW(a_count_bound, 1'b1, count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH), "queue overfilled")
   `CHECK_NEXT(a_push_grows, do_push && !do_pop, count_ff == $past(count_ff) + QUEUE_CNT_W'(1), "push lost")
   `CHECK_NOW(a_ptr_track, stat.empty || stat.full, wr_ptr_ff == rd_ptr_ff, "pointers disagree with count")

endmodule

`default_nettype wire

FILE: rtl/sitda_back.sv
// back end: bit-serial double dabble, digit count, then one character per cycle unless stalled
// depends on sitda_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none

module sitda_back
   import sitda_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEF
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire queue_stat_type q_stat,
   input  wire job_type        job,
   output logic                pop,
   output logic                rsp_valid,
   input  wire logic           rsp_ready,
   output rsp_type             rsp_data
);

   localparam int BIT_CNT_W = $clog2(VALUE_BITS + 1);

   back_state_type state_ff, state_in;

   logic [VALUE_BITS-1:0]  mag_ff, mag_in;
   logic                   neg_ff, neg_in;
   logic [SIZE_W-1:0]      cap_ff, cap_in;
   logic [3:0]             bcd_ff [DIGIT_COUNT];
   logic [3:0]             bcd_in [DIGIT_COUNT];
   logic [3:0]             adj    [DIGIT_COUNT];
   logic [BIT_CNT_W-1:0]   bit_cnt_ff, bit_cnt_in;
   logic [DIGIT_IDX_W-1:0] idx_ff, idx_in;
   logic                   sign_pend_ff, sign_pend_in;
   logic [LEN_W-1:0]       cnt_ff, cnt_in;
   logic [LEN_W-1:0]       total_ff, total_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;

   logic                   out_free;
   logic                   conv_done;
   logic                   emit_last;
   logic [LEN_W-1:0]       ndig;
   logic [LEN_W-1:0]       nchar;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign conv_done = (bit_cnt_ff == BIT_CNT_W'(VALUE_BITS - 1));
   assign emit_last = (total_ff == '0) || (cnt_ff + LEN_W'(1) == total_ff);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // add-3 correction on every digit, independent per digit
   always_comb begin
      for (int i = 0; i < DIGIT_COUNT; i++) begin
         adj[i] = (bcd_ff[i] >= DABBLE_MIN) ? (bcd_ff[i] + DABBLE_ADD) : bcd_ff[i];
      end
   end

   // leading nonzero digit, at least one digit for zero
   always_comb begin
      ndig = LEN_W'(1);
      for (int i = 0; i < DIGIT_COUNT; i++) begin
         if (bcd_ff[i] != '0) begin
            ndig = LEN_W'(i + 1);
         end
      end
      nchar = ndig + LEN_W'(neg_ff);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (!q_stat.empty) state_in = BK_CONVERT;
         end
         BK_CONVERT: begin
            if (conv_done) state_in = BK_COUNT;
         end
         BK_COUNT: begin
            state_in = BK_EMIT;
         end
         BK_EMIT: begin
            if (out_free && emit_last) state_in = BK_IDLE;
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      pop          = 1'b0;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      cap_in       = cap_ff;
      bcd_in       = bcd_ff;
      bit_cnt_in   = bit_cnt_ff;
      idx_in       = idx_ff;
      sign_pend_in = sign_pend_ff;
      cnt_in       = cnt_ff;
      total_in     = total_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         BK_IDLE: begin
            if (!q_stat.empty) begin
               pop        = 1'b1;
               mag_in     = job.mag[VALUE_BITS-1:0];
               neg_in     = job.neg;
               cap_in     = job.cap;
               bit_cnt_in = '0;
               for (int i = 0; i < DIGIT_COUNT; i++) begin
                  bcd_in[i] = '0;
               end
            end
         end
         BK_CONVERT: begin
            bcd_in[0] = {adj[0][2:0], mag_ff[VALUE_BITS-1]};
            for (int i = 1; i < DIGIT_COUNT; i++) begin
               bcd_in[i] = {adj[i][2:0], adj[i-1][3]};
            end
            mag_in     = mag_ff << 1;
            bit_cnt_in = bit_cnt_ff + BIT_CNT_W'(1);
         end
         BK_COUNT: begin
            idx_in       = DIGIT_IDX_W'(ndig - LEN_W'(1));
            sign_pend_in = neg_ff;
            cnt_in       = '0;
            total_in     = ({(SIZE_W - LEN_W)'(0), nchar} < cap_ff) ? nchar : cap_ff[LEN_W-1:0];
         end
         BK_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (total_ff == '0) begin
                  // buffer size of one or zero: a single empty item
                  rsp_data_in.ch         = '0;
                  rsp_data_in.char_valid = 1'b0;
                  rsp_data_in.last       = 1'b1;
                  rsp_data_in.length     = '0;
               end else begin
                  rsp_data_in.ch         = sign_pend_ff ? ASCII_MINUS
                                         : (ASCII_ZERO + {4'b0000, bcd_ff[idx_ff]});
                  rsp_data_in.char_valid = 1'b1;
                  rsp_data_in.last       = emit_last;
                  rsp_data_in.length     = emit_last ? total_ff : '0;
                  if (sign_pend_ff) begin
                     sign_pend_in = 1'b0;
                  end else begin
                     idx_in = idx_ff - DIGIT_IDX_W'(1);
                  end
                  cnt_in = cnt_ff + LEN_W'(1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff       <= mag_in;
      neg_ff       <= neg_in;
      cap_ff       <= cap_in;
      bcd_ff       <= bcd_in;
      bit_cnt_ff   <= bit_cnt_in;
      idx_ff       <= idx_in;
      sign_pend_ff <= sign_pend_in;
      cnt_ff       <= cnt_in;
      total_ff     <= total_in;
      rsp_data_ff  <= rsp_data_in;
   end

`include "assert_macros.svh"

   `CHECK_NOW(a_len_on_last, rsp_valid_ff && !rsp_data_ff.last, rsp_data_ff.length == '0, "length on non-last item")
   `CHECK_NOW(a_empty_is_last, rsp_valid_ff && !rsp_data_ff.char_valid, rsp_data_ff.last && (rsp_data_ff.length == '0), "bad empty item")
   `CHECK_NOW(a_emit_bound, state_ff == BK_EMIT, cnt_ff < total_ff || total_ff == '0, "emitted past total")
   `CHECK_NEXT(a_pop_starts, pop, state_ff == BK_CONVERT, "pop without conversion")

endmodule

`default_nettype wire

FILE: sim/testbench.sv
// testbench for signed_int_to_decimal_ascii_top: directed and random requests,
// a local text predictor and an in-order checker of every character response
// depends on sitda_pkg and the rtl of the converter
`timescale 1ns / 1ps

module testbench;
   import sitda_pkg::*;

   localparam int MAX_TEXT      = 20;     // 19 digits plus a sign
   localparam int LONG_STALL    = 400;    // cycles of forced rsp_ready low
   localparam int IDLE_LIMIT    = 5000;   // cycles without any handshake
   localparam int SETTLE_CYCLES = VALUE_BITS_DEF + 40;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // characters still owed by the block, oldest first
   rsp_type expected_chars[$];
   int      mismatch_count = 0;
   int      send_idle_pct = 0;
   int      recv_idle_pct = 0;
   logic    hold_rsp_request = 1'b0;

   signed_int_to_decimal_ascii_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // decimal text of one request, cut to the buffer, as response items
   function automatic void predict_text(input req_type item);
      logic [VALUE_W-1:0] mag;
      logic               neg;
      logic [7:0]         rev [MAX_TEXT];
      int                 n;
      int                 cap;
      int                 emit;
      rsp_type            r;
      neg = item.value[VALUE_W-1];
      mag = item.value;
      if (neg) begin
         mag = -mag;  // most negative value wraps to 2**63 unsigned
      end
      n = 0;
      // least significant digit first, zero gives a single '0'
      do begin
         rev[n] = ASCII_ZERO + 8'(mag % 10);
         mag    = mag / 10;
         n++;
      end while (mag != 0 && n < MAX_TEXT);
      if (neg && n < MAX_TEXT) begin
         rev[n] = ASCII_MINUS;
         n++;
      end
      // a zero size is treated as one
      cap  = ((item.buffer_size == 0) ? 1 : int'(item.buffer_size)) - 1;
      emit = (n < cap) ? n : cap;
      if (emit == 0) begin
         r.ch         = '0;
         r.char_valid = 1'b0;
         r.last       = 1'b1;
         r.length     = '0;
         expected_chars.push_back(r);
      end else begin
         for (int i = 0; i < emit; i++) begin
            r.ch         = rev[n - 1 - i];
            r.char_valid = 1'b1;
            r.last       = (i == emit - 1);
            r.length     = (i == emit - 1) ? LEN_W'(emit) : '0;
            expected_chars.push_back(r);
         end
      end
   endfunction

   // offer one request, with a random gap first, and record its text once taken
   task automatic send_request(input logic [VALUE_W-1:0] value, input logic [SIZE_W-1:0] size);
      req_type item;
      item.value       = value;
      item.buffer_size = size;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      predict_text(item);
   endtask

   task automatic wait_all_results();
      while (expected_chars.size() != 0) @(posedge clock);
   endtask

   function automatic logic [VALUE_W-1:0] rand_value();
      logic [VALUE_W-1:0] v;
      logic [VALUE_W-1:0] p;
      case ($urandom_range(5))
         0: v = {$urandom, $urandom};
         1: v = VALUE_W'($urandom_range(999));
         2: begin
            p = 1;
            repeat ($urandom_range(18)) p = p * 10;
            v = p + VALUE_W'($urandom_range(2)) - 1;  // power of ten and its neighbors
         end
         3: v = {1'b0, {(VALUE_W-1){1'b1}}} - VALUE_W'($urandom_range(3));
         4: v = VALUE_W'(signed'($urandom));
         default: v = {$urandom, $urandom} >> $urandom_range(VALUE_W - 1);
      endcase
      if ($urandom_range(1)) begin
         v = -v;
      end
      return v;
   endfunction

   function automatic logic [SIZE_W-1:0] rand_size();
      // mostly room for the whole text, often a cut one
      if ($urandom_range(99) < 60) begin
         return SIZE_W'($urandom_range(255, 21));
      end
      return SIZE_W'($urandom_range(22));
   endfunction

   // extremes of both fields, empty output and truncation
   task automatic test_directed();
      send_request(64'd0, 8'd255);
      send_request(64'd0, 8'd2);
      send_request(64'd1, 8'd3);
      send_request(-64'sd1, 8'd3);
      send_request(-64'sd1, 8'd2);                        // sign alone
      send_request(64'd9, 8'd2);
      send_request(64'd10, 8'd255);
      send_request(-64'sd10, 8'd4);
      send_request(64'h7fff_ffff_ffff_ffff, 8'd255);
      send_request(64'h7fff_ffff_ffff_ffff, 8'd20);       // exactly fits
      send_request(64'h7fff_ffff_ffff_ffff, 8'd19);
      send_request(64'h8000_0000_0000_0000, 8'd21);       // most negative, full
      send_request(64'h8000_0000_0000_0000, 8'd20);
      send_request(64'h8000_0000_0000_0000, 8'd255);
      send_request(64'h8000_0000_0000_0001, 8'd255);
      send_request(64'd12345, 8'd1);                      // empty item
      send_request(-64'sd12345, 8'd0);                    // zero size acts as one
      send_request(64'd12345, 8'd4);
      send_request(64'hffff_ffff_ffff_ffff, 8'd255);
      send_request(64'd1000000000000000000, 8'd255);
      send_request(64'hffff_ffff_0000_0000, 8'd128);
      send_request(64'h5555_5555_aaaa_aaaa, 8'd127);
   endtask

   // receiver holds off for a long stretch while requests keep coming
   task automatic test_backpressure();
      int saved_pct;
      saved_pct        = send_idle_pct;
      send_idle_pct    = 0;
      hold_rsp_request = 1'b1;
      repeat (8) send_request(rand_value(), rand_size());
      send_idle_pct = saved_pct;
   endtask

   // sender goes quiet until the block has drained
   task automatic test_sender_pause();
      req_valid <= 1'b0;
      wait_all_results();
      repeat ($urandom_range(5)) @(posedge clock);
   endtask

   task automatic test_random(input int count);
      repeat (count) send_request(rand_value(), rand_size());
   endtask

   // receiver: random stalls, or a long hold-off when asked
   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (hold_rsp_request) begin
            hold_rsp_request = 1'b0;
            stall_left       = LONG_STALL;
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // compare each accepted response with the oldest owed character
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_chars.size() == 0) begin
            $error("unexpected response ch %0h last %0b", rsp_data.ch, rsp_data.last);
            mismatch_count++;
         end else begin
            want = expected_chars.pop_front();
            if (rsp_data.ch !== want.ch) begin
               $error("ch: expected %0h, got %0h", want.ch, rsp_data.ch);
               mismatch_count++;
            end
            if (rsp_data.char_valid !== want.char_valid) begin
               $error("char_valid: expected %0b, got %0b", want.char_valid,
                      rsp_data.char_valid);
               mismatch_count++;
            end
            if (rsp_data.last !== want.last) begin
               $error("last: expected %0b, got %0b", want.last, rsp_data.last);
               mismatch_count++;
            end
            if (rsp_data.length !== want.length) begin
               $error("length: expected %0d, got %0d", want.length, rsp_data.length);
               mismatch_count++;
            end
         end
      end
   end

   // watchdog on cycles with no handshake on either channel
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("[signed_int_to_decimal_ascii_top] ERROR");
      $finish;
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 38;
      recv_idle_pct = 49;
      test_directed();
      test_backpressure();
      test_random(100);
      test_sender_pause();

      send_idle_pct = 49;
      recv_idle_pct = 38;
      test_random(100);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random(100);

      req_valid <= 1'b0;
      wait_all_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_chars.size() == 0) begin
         $display("[signed_int_to_decimal_ascii_top] OK");
      end else begin
         $display("[signed_int_to_decimal_ascii_top] ERROR");
      end
      $finish;
   end

endmodule
